### src/text_tile_cursor_writer_defines.svh
// ---------------------------------------------------------------------------
// text tile cursor writer assertion macros
// shared concurrent assertion forms, clocked on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef TEXT_TILE_CURSOR_WRITER_DEFINES_SVH
`define TEXT_TILE_CURSOR_WRITER_DEFINES_SVH

// same-cycle implication
`define TTCW_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TTCW_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/ttcw_pkg.sv
// ---------------------------------------------------------------------------
// ttcw_pkg
// shared types, register codes and the character to glyph map
// ---------------------------------------------------------------------------
package ttcw_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int GLYPH_W    = 8;
    localparam int PAL_W      = 4;
    localparam int ENTRY_W    = 16;
    localparam int NUM_LATIN  = 18;

    typedef logic [1:0] rot_mode_t;

    localparam rot_mode_t ROT_NONE    = 2'd0;
    localparam rot_mode_t ROT_RIGHT   = 2'd1;
    localparam rot_mode_t ROT_LEFT    = 2'd2;
    localparam rot_mode_t ROT_INVALID = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROTATION_MODE    = 3'd0,
        REG_LAST_COLUMN      = 3'd1,
        REG_LAST_ROW         = 3'd2,
        REG_PALETTE_NUMBER   = 3'd3,
        REG_LAST_VALID_GLYPH = 3'd4
    } cfg_reg_t;

    localparam logic [7:0]         NEWLINE_BYTE       = 8'd10;
    localparam logic [7:0]         PRINT_FIRST        = 8'd32;
    localparam logic [7:0]         PRINT_END          = 8'd128;
    localparam logic [GLYPH_W-1:0] GLYPH_LATIN_BASE   = 8'd96;
    localparam logic [GLYPH_W-1:0] RST_LAST_GLYPH     = 8'd113;
    localparam int                 RST_LAST_COORD     = 31;

    localparam logic [7:0] LATIN_CODES [NUM_LATIN] = '{
        8'd199, 8'd231, 8'd209, 8'd241, 8'd193, 8'd201, 8'd205, 8'd211, 8'd218,
        8'd225, 8'd233, 8'd237, 8'd243, 8'd250, 8'd239, 8'd252, 8'd161, 8'd191
    };

    typedef struct packed {
        rot_mode_t            rotation_mode;
        logic [PAL_W-1:0]     palette_number;
        logic [GLYPH_W-1:0]   last_valid_glyph;
    } cfg_ctrl_t;

    // printable ascii, then the latin-1 letters, everything else glyph 0
    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [7:0] b);
        logic [GLYPH_W-1:0] g;
        g = '0;
        if (b >= PRINT_FIRST && b < PRINT_END)
        begin
            g = b - PRINT_FIRST;
        end
        else if (b >= PRINT_END)
        begin
            for (int i = 0; i < NUM_LATIN; i++)
            begin
                if (LATIN_CODES[i] == b)
                begin
                    g = GLYPH_LATIN_BASE + GLYPH_W'(i);
                end
            end
        end
        return g;
    endfunction

endpackage

### src/ttcw_in_if.sv
// ---------------------------------------------------------------------------
// ttcw_in_if
// character item channel: begin flag, start position and byte
// ---------------------------------------------------------------------------
interface ttcw_in_if #(
    parameter int COORD_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic                  begin_string;
    logic [COORD_BITS-1:0] start_column;
    logic [COORD_BITS-1:0] start_row;
    logic [7:0]            char_byte;

    modport source (
        output valid, begin_string, start_column, start_row, char_byte,
        input  ready
    );

    modport sink (
        input  valid, begin_string, start_column, start_row, char_byte,
        output ready
    );
endinterface

### src/ttcw_out_if.sv
// ---------------------------------------------------------------------------
// ttcw_out_if
// tile write item channel: map position and map entry
// ---------------------------------------------------------------------------
interface ttcw_out_if #(
    parameter int COORD_BITS = 6
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] tile_column;
    logic [COORD_BITS-1:0] tile_row;
    logic [15:0]           tile_entry;

    modport source (
        output valid, tile_column, tile_row, tile_entry,
        input  ready
    );

    modport sink (
        input  valid, tile_column, tile_row, tile_entry,
        output ready
    );
endinterface

### src/ttcw_cfg_regs.sv
// ---------------------------------------------------------------------------
// ttcw_cfg_regs
// configuration register file with plain write port
// ---------------------------------------------------------------------------
module ttcw_cfg_regs #(
    parameter int COORD_BITS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [ttcw_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [ttcw_pkg::CFG_DATA_W-1:0]   wr_data,
    output ttcw_pkg::cfg_ctrl_t               ctrl,
    output logic [COORD_BITS-1:0]             last_column,
    output logic [COORD_BITS-1:0]             last_row
);
    import ttcw_pkg::*;

    cfg_ctrl_t             ctrl_reg, ctrl_next;
    logic [COORD_BITS-1:0] last_col_reg, last_col_next;
    logic [COORD_BITS-1:0] last_row_reg, last_row_next;

    always_comb
    begin
        ctrl_next     = ctrl_reg;
        last_col_next = last_col_reg;
        last_row_next = last_row_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_ROTATION_MODE:    ctrl_next.rotation_mode    = wr_data[1:0];
                REG_LAST_COLUMN:      last_col_next              = wr_data[COORD_BITS-1:0];
                REG_LAST_ROW:         last_row_next              = wr_data[COORD_BITS-1:0];
                REG_PALETTE_NUMBER:   ctrl_next.palette_number   = wr_data[PAL_W-1:0];
                REG_LAST_VALID_GLYPH: ctrl_next.last_valid_glyph = wr_data[GLYPH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.rotation_mode    <= ROT_NONE;
            ctrl_reg.palette_number   <= '0;
            ctrl_reg.last_valid_glyph <= RST_LAST_GLYPH;
            last_col_reg              <= COORD_BITS'(RST_LAST_COORD);
            last_row_reg              <= COORD_BITS'(RST_LAST_COORD);
        end
        else
        begin
            ctrl_reg     <= ctrl_next;
            last_col_reg <= last_col_next;
            last_row_reg <= last_row_next;
        end
    end

    assign ctrl        = ctrl_reg;
    assign last_column = last_col_reg;
    assign last_row    = last_row_reg;

endmodule

### src/ttcw_cursor.sv
// ---------------------------------------------------------------------------
// ttcw_cursor
// cursor state, glyph lookup, layer check and line break / wrap
// ---------------------------------------------------------------------------
`include "text_tile_cursor_writer_defines.svh"

module ttcw_cursor #(
    parameter int COORD_BITS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              step,
    input  logic                              begin_string,
    input  logic [COORD_BITS-1:0]             start_column,
    input  logic [COORD_BITS-1:0]             start_row,
    input  logic [7:0]                        char_byte,
    input  ttcw_pkg::cfg_ctrl_t               ctrl,
    input  logic [COORD_BITS-1:0]             last_column,
    input  logic [COORD_BITS-1:0]             last_row,
    output logic                              res_valid,
    output logic [COORD_BITS-1:0]             res_column,
    output logic [COORD_BITS-1:0]             res_row,
    output logic [ttcw_pkg::ENTRY_W-1:0]      res_entry
);
    import ttcw_pkg::*;

    // two extra bits: sign, and one step past either edge of the layer
    localparam int CW = COORD_BITS + 2;
    localparam logic signed [CW-1:0] ONE     = CW'(1);
    localparam logic signed [CW-1:0] CUR_MAX = CW'(1) <<< COORD_BITS;
    localparam logic signed [CW-1:0] CUR_MIN = -CUR_MAX;

    logic signed [CW-1:0] col_reg, col_next;
    logic signed [CW-1:0] row_reg, row_next;

    logic signed [CW-1:0] w_s, h_s, sx_s, sy_s;
    logic signed [CW-1:0] col0, row0, col1, row1, col2, row2;
    logic [GLYPH_W-1:0]   glyph;
    logic                 nl;
    logic                 wr;
    logic                 in_layer;
    logic                 mode_ok;

    assign w_s  = signed'({2'b00, last_column});
    assign h_s  = signed'({2'b00, last_row});
    assign sx_s = signed'({2'b00, start_column});
    assign sy_s = signed'({2'b00, start_row});

    assign glyph   = glyph_of(char_byte);
    assign nl      = (char_byte == NEWLINE_BYTE);
    assign wr      = !nl && (glyph <= ctrl.last_valid_glyph);
    assign mode_ok = (ctrl.rotation_mode != ROT_INVALID);

    always_comb
    begin
        col0 = col_reg;
        row0 = row_reg;
        if (begin_string)
        begin
            case (ctrl.rotation_mode)
                ROT_NONE:
                begin
                    col0 = sx_s;
                    row0 = sy_s;
                end
                ROT_RIGHT:
                begin
                    col0 = w_s - sy_s;
                    row0 = sx_s;
                end
                ROT_LEFT:
                begin
                    col0 = sy_s;
                    row0 = h_s - sx_s;
                end
                default: ;
            endcase
        end

        in_layer = !col0[CW-1] && (col0 <= w_s) && !row0[CW-1] && (row0 <= h_s);

        // advance along the line only for a writable glyph, even one outside the layer
        col1 = col0;
        row1 = row0;
        if (wr)
        begin
            case (ctrl.rotation_mode)
                ROT_NONE:  col1 = col0 + ONE;
                ROT_RIGHT: row1 = row0 + ONE;
                ROT_LEFT:  row1 = row0 - ONE;
                default: ;
            endcase
        end

        // line break, then wrap across lines
        col2 = col1;
        row2 = row1;
        case (ctrl.rotation_mode)
            ROT_NONE:
            begin
                if (col1 > w_s || nl)
                begin
                    col2 = '0;
                    row2 = row1 + ONE;
                    if (row2 > h_s)
                    begin
                        row2 = '0;
                    end
                end
            end
            ROT_RIGHT:
            begin
                if (row1 > h_s || nl)
                begin
                    row2 = '0;
                    col2 = col1 - ONE;
                    if (col2[CW-1])
                    begin
                        col2 = w_s;
                    end
                end
            end
            ROT_LEFT:
            begin
                if (row1[CW-1] || nl)
                begin
                    row2 = h_s;
                    col2 = col1 + ONE;
                    if (col2 > w_s)
                    begin
                        col2 = '0;
                    end
                end
            end
            default: ;
        endcase

        col_next = col_reg;
        row_next = row_reg;
        if (step && mode_ok)
        begin
            col_next = col2;
            row_next = row2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign res_valid  = mode_ok && wr && in_layer;
    assign res_column = col0[COORD_BITS-1:0];
    assign res_row    = row0[COORD_BITS-1:0];
    assign res_entry  = {ctrl.palette_number, 4'h0, glyph};

    `TTCW_ASSERT_IMP(a_cursor_bounded, 1'b1, (col_reg >= CUR_MIN) && (col_reg <= CUR_MAX) && (row_reg >= CUR_MIN) && (row_reg <= CUR_MAX), "cursor outside its range")
    `TTCW_ASSERT_NXT(a_col_inside_unrotated, step && ctrl.rotation_mode == ROT_NONE, col_reg <= w_s, "column past last column after unrotated step")
    `TTCW_ASSERT_NXT(a_newline_right, step && ctrl.rotation_mode == ROT_RIGHT && nl, row_reg == '0, "newline did not reset row when rotated right")

endmodule

### src/text_tile_cursor_writer.sv
// an accepted item goes to the input stage, then its tile write to the result stage
// throughput: one item per cycle unless out_ch stalls, set by the cursor loop
// an item that writes nothing leaves no result; it may still move the cursor
// reset clears the cursor to (0, 0) and loads the register defaults:
// no rotation, last column and row 31, palette 0, last valid glyph 113
// ---------------------------------------------------------------------------
// text_tile_cursor_writer
// turns a stream of character bytes into tile-map writes for a text layer
// ---------------------------------------------------------------------------
`include "text_tile_cursor_writer_defines.svh"

module text_tile_cursor_writer #(
    parameter int COORD_BITS = 6
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [ttcw_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ttcw_pkg::CFG_DATA_W-1:0]   cfg_data,
    ttcw_in_if.sink                           in_ch,
    ttcw_out_if.source                        out_ch
);
    import ttcw_pkg::*;

    cfg_ctrl_t             ctrl;
    logic [COORD_BITS-1:0] last_column;
    logic [COORD_BITS-1:0] last_row;

    // input stage
    logic                  s1_valid_reg, s1_valid_next;
    logic                  s1_begin_reg;
    logic [COORD_BITS-1:0] s1_col_reg;
    logic [COORD_BITS-1:0] s1_row_reg;
    logic [7:0]            s1_char_reg;

    // result stage
    logic                  out_valid_reg, out_valid_next;
    logic [COORD_BITS-1:0] out_col_reg;
    logic [COORD_BITS-1:0] out_row_reg;
    logic [ENTRY_W-1:0]    out_entry_reg;

    logic                  res_valid;
    logic [COORD_BITS-1:0] res_column;
    logic [COORD_BITS-1:0] res_row;
    logic [ENTRY_W-1:0]    res_entry;

    logic out_free;
    logic s1_go;
    logic in_fire;

    ttcw_cfg_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (cfg_wr_en),
        .wr_index    (cfg_index),
        .wr_data     (cfg_data),
        .ctrl        (ctrl),
        .last_column (last_column),
        .last_row    (last_row)
    );

    ttcw_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (s1_go),
        .begin_string (s1_begin_reg),
        .start_column (s1_col_reg),
        .start_row    (s1_row_reg),
        .char_byte    (s1_char_reg),
        .ctrl         (ctrl),
        .last_column  (last_column),
        .last_row     (last_row),
        .res_valid    (res_valid),
        .res_column   (res_column),
        .res_row      (res_row),
        .res_entry    (res_entry)
    );

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign s1_go       = s1_valid_reg && out_free;
    assign in_ch.ready = !s1_valid_reg || out_free;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ch.ready)
        begin
            s1_valid_next = in_ch.valid;
        end

        out_valid_next = out_valid_reg;
        if (s1_go)
        begin
            out_valid_next = res_valid;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_begin_reg <= in_ch.begin_string;
            s1_col_reg   <= in_ch.start_column;
            s1_row_reg   <= in_ch.start_row;
            s1_char_reg  <= in_ch.char_byte;
        end
        if (s1_go && res_valid)
        begin
            out_col_reg   <= res_column;
            out_row_reg   <= res_row;
            out_entry_reg <= res_entry;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.tile_column = out_col_reg;
    assign out_ch.tile_row    = out_row_reg;
    assign out_ch.tile_entry  = out_entry_reg;

    `TTCW_ASSERT_NXT(a_accept_fills_stage, in_fire, s1_valid_reg, "accepted item lost before the cursor stage")
    `TTCW_ASSERT_NXT(a_stage_holds_on_stall, s1_valid_reg && !out_free, s1_valid_reg && $stable(s1_char_reg), "stalled item left the cursor stage")
    `TTCW_ASSERT_IMP(a_newline_no_write, s1_valid_reg && s1_char_reg == NEWLINE_BYTE, !res_valid, "newline produced a tile write")

endmodule
